>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SLPG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Expression must never be true outside reset.
`define SLPG_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`endif

>>> src/slpg_pkg.sv
// Types, constants and helpers for the status LED pattern generator.
package slpg_pkg;

  localparam int unsigned LedW      = 4;
  localparam int unsigned StampW    = 32;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned StepW     = 2;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgSequenceStep = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSearchPhase  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBlink        = 2'd2;

  localparam logic [IntervalW-1:0] SequenceStepRst = 16'd250;
  localparam logic [IntervalW-1:0] SearchPhaseRst  = 16'd150;
  localparam logic [IntervalW-1:0] BlinkRst        = 16'd500;

  localparam logic [LedW-1:0] LedsDark  = 4'h0;
  localparam logic [LedW-1:0] LedsAll   = 4'hF;
  localparam logic [LedW-1:0] LedsFirst = 4'h1;
  localparam logic [LedW-1:0] LedsOuter = 4'h9;
  localparam logic [LedW-1:0] LedsInner = 4'h6;

  localparam logic [StepW-1:0] SearchOuterStep = 2'd0;
  localparam logic [StepW-1:0] SearchInnerStep = 2'd2;

  typedef struct packed {
    logic [IntervalW-1:0] sequence_step_ms;
    logic [IntervalW-1:0] search_phase_ms;
    logic [IntervalW-1:0] blink_ms;
  } cfg_t;

  typedef struct packed {
    logic              in_done_mode;
    logic              in_search_mode;
    logic              blink_lit;
    logic [StampW-1:0] blink_stamp;
    logic [StepW-1:0]  walk_position;
    logic              walk_lit_phase;
    logic [StampW-1:0] walk_stamp;
    logic [StepW-1:0]  search_step;
    logic [StampW-1:0] search_stamp;
    logic [LedW-1:0]   led_register;
  } state_t;

  localparam state_t StateRst = '{
    in_done_mode:   1'b0,
    in_search_mode: 1'b0,
    blink_lit:      1'b1,
    blink_stamp:    '0,
    walk_position:  '0,
    walk_lit_phase: 1'b1,
    walk_stamp:     '0,
    search_step:    '0,
    search_stamp:   '0,
    led_register:   LedsDark
  };

  function automatic logic [LedW-1:0] search_pattern(input logic [StepW-1:0] step);
    logic [LedW-1:0] leds;
    case (step)
      SearchOuterStep: leds = LedsOuter;
      SearchInnerStep: leds = LedsInner;
      default:         leds = LedsDark;
    endcase
    return leds;
  endfunction

  // Wrapping elapsed-time check
  function automatic logic interval_elapsed(input logic [StampW-1:0]    now,
                                            input logic [StampW-1:0]    stamp,
                                            input logic [IntervalW-1:0] interval);
    logic [StampW-1:0] diff;
    diff = now - stamp;
    return diff >= {{(StampW-IntervalW){1'b0}}, interval};
  endfunction

endpackage

>>> src/slpg_if.sv
// Stream and configuration channel interfaces.
interface slpg_in_if import slpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [StampW-1:0] now_ms;
  logic              is_running;
  logic              is_searching;
  logic              is_done;

  modport source (output valid, now_ms, is_running, is_searching, is_done, input ready);
  modport sink   (input valid, now_ms, is_running, is_searching, is_done, output ready);
endinterface

interface slpg_out_if import slpg_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [LedW-1:0] led_levels;

  modport source (output valid, led_levels, input ready);
  modport sink   (input valid, led_levels, output ready);
endinterface

interface slpg_cfg_if import slpg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CfgIdxW-1:0]   index;
  logic [IntervalW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/status_led_pattern_generator.sv
// An accepted tick beat passes the input register and then the result register to become its LED beat.
// Throughput: one tick per cycle unless the output stalls; the pattern state updates in the same
// cycle the result register loads, so the next tick sees it without a bubble.
// Reset: rst_ni clears the pattern state, mode memory and beat flags and loads the interval
// registers with their defaults; no clearing sweep, the block is ready right after reset.
module status_led_pattern_generator import slpg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  slpg_cfg_if.sink         cfg_i,
  slpg_in_if.sink          in_i,
  slpg_out_if.source       out_o
);

  cfg_t              cfg_q;
  state_t            state_q, state_d;
  logic              s1_valid_q;
  logic [StampW-1:0] s1_now_q;
  logic              s1_running_q, s1_searching_q, s1_done_q;
  logic              out_valid_q;
  logic [LedW-1:0]   out_leds_q;
  logic              advance;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sequence_step_ms <= SequenceStepRst;
      cfg_q.search_phase_ms  <= SearchPhaseRst;
      cfg_q.blink_ms         <= BlinkRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgSequenceStep: cfg_q.sequence_step_ms <= cfg_i.data;
        CfgSearchPhase:  cfg_q.search_phase_ms  <= cfg_i.data;
        CfgBlink:        cfg_q.blink_ms         <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // result register is free or being drained this cycle
  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_now_q       <= in_i.now_ms;
      s1_running_q   <= in_i.is_running;
      s1_searching_q <= in_i.is_searching;
      s1_done_q      <= in_i.is_done;
    end
  end

  slpg_step u_step (
    .state_i        (state_q),
    .cfg_i          (cfg_q),
    .now_ms_i       (s1_now_q),
    .is_running_i   (s1_running_q),
    .is_searching_i (s1_searching_q),
    .is_done_i      (s1_done_q),
    .state_o        (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateRst;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_leds_q <= state_d.led_register;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.led_levels = out_leds_q;

endmodule

>>> src/slpg_step.sv
// Next-state logic for one tick of the LED pattern generator.
module slpg_step import slpg_pkg::*; (
  input  state_t            state_i,
  input  cfg_t              cfg_i,
  input  logic [StampW-1:0] now_ms_i,
  input  logic              is_running_i,
  input  logic              is_searching_i,
  input  logic              is_done_i,
  output state_t            state_o
);

  always_comb begin
    state_t nx;
    nx = state_i;
    if (!is_running_i && !is_done_i) begin
      nx.led_register   = LedsDark;
      nx.in_done_mode   = 1'b0;
      nx.in_search_mode = 1'b0;
    end else if (is_done_i) begin
      if (!state_i.in_done_mode) begin
        nx.in_done_mode   = 1'b1;
        nx.in_search_mode = 1'b0;
        nx.walk_position  = '0;
        nx.walk_lit_phase = 1'b1;
        nx.walk_stamp     = now_ms_i;
        nx.led_register   = LedsFirst;
      end
      if (interval_elapsed(now_ms_i, nx.walk_stamp, cfg_i.sequence_step_ms)) begin
        nx.walk_stamp = now_ms_i;
        if (nx.walk_lit_phase) begin
          nx.led_register   = nx.led_register & ~(LedsFirst << nx.walk_position);
          nx.walk_lit_phase = 1'b0;
        end else begin
          nx.walk_position  = nx.walk_position + 1'b1;
          nx.led_register   = nx.led_register | (LedsFirst << nx.walk_position);
          nx.walk_lit_phase = 1'b1;
        end
      end
    end else if (is_searching_i) begin
      if (!state_i.in_search_mode) begin
        nx.in_search_mode = 1'b1;
        nx.in_done_mode   = 1'b0;
        nx.search_step    = SearchOuterStep;
        nx.search_stamp   = now_ms_i;
        nx.led_register   = LedsOuter;
      end
      if (interval_elapsed(now_ms_i, nx.search_stamp, cfg_i.search_phase_ms)) begin
        nx.search_stamp = now_ms_i;
        nx.search_step  = nx.search_step + 1'b1;
        nx.led_register = search_pattern(nx.search_step);
      end
    end else begin
      // coming straight from off keeps the old blink phase and stamp
      if (state_i.in_done_mode || state_i.in_search_mode) begin
        nx.in_done_mode   = 1'b0;
        nx.in_search_mode = 1'b0;
        nx.blink_lit      = 1'b1;
        nx.blink_stamp    = now_ms_i;
        nx.led_register   = LedsAll;
      end
      if (interval_elapsed(now_ms_i, nx.blink_stamp, cfg_i.blink_ms)) begin
        nx.blink_stamp  = now_ms_i;
        nx.blink_lit    = ~nx.blink_lit;
        nx.led_register = nx.blink_lit ? LedsAll : LedsDark;
      end
    end
    state_o = nx;
  end

endmodule

>>> src/slpg_checker.sv
// Port-level checks for the status LED pattern generator, with its bind.
`include "assert_macros.svh"

module slpg_checker import slpg_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [LedW-1:0] led_levels_i
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  // a stalled result beat keeps its value
  `SLPG_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(led_levels_i), "result beat changed while stalled")

  // input is only held off when a result is waiting downstream
  `SLPG_ASSERT_NEVER(a_no_idle_stall, clk_i, rst_ni, !in_ready_i && !(out_valid_i && !out_ready_i), "input stalled without output backpressure")

  // a result beat is only raised by a tick beat that passed the input and result registers
  `SLPG_ASSERT(a_out_from_in, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_beat, 2), "result beat without a matching tick beat")

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .led_levels_i (out_o.led_levels)
);
